FILE: src/assert_macros.svh
// Assertion macros shared by the visited key set RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VKHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define VKHS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/vkhs_pkg.sv
// Package for the visited key set: item types, hash constants, control structs.
// Used by vkhs_controller, vkhs_datapath and visited_key_hash_set.
package vkhs_pkg;

   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int KEY_W = 64;
   localparam int HASH_W = 32;
   localparam int MOD_STEPS = 3;
   localparam logic [HASH_W-1:0] HASH_MULT = 32'd2654435761;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] device_id;
      logic [KEY_W-1:0] inode_number;
   } req_type;

   typedef struct packed {
      logic found_before;
      logic inserted;
      logic table_full;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic load_item;
      logic mul_lo;
      logic mul_hi;
      logic fold;
      logic pos_from_hash;
      logic mod_step;
      logic pos_from_rem;
      logic rd;
      logic check;
      logic advance;
      logic hold_res;
      logic rsp_from_check;
      logic rsp_from_hold;
   } cmd_type;

   typedef struct packed {
      logic used;
      logic key_match;
      logic probe_last;
      logic pos_last;
   } status_type;

endpackage

FILE: src/vkhs_datapath.sv
// Datapath of the visited key set: key hash, slot index reduction, slot memory, result registers.
// Depends on vkhs_pkg; driven by vkhs_controller through cmd_type and status_type.
module vkhs_datapath #(
   parameter int TABLE_SLOTS = vkhs_pkg::TABLE_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vkhs_pkg::cmd_type                  cmd,
   input  vkhs_pkg::req_type                  req_data,
   output vkhs_pkg::status_type               status,
   output vkhs_pkg::rsp_type                  rsp_data,
   output logic [$clog2(TABLE_SLOTS+1)-1:0]   stored_count
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_W = vkhs_pkg::KEY_W;
   localparam int HASH_W = vkhs_pkg::HASH_W;
   localparam int SLOT_W = 1 + 2 * KEY_W;
   localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_SLOTS);

   logic [SLOT_W-1:0] slot_mem [TABLE_SLOTS];

   vkhs_pkg::req_type   item_ff, item_in;
   logic [2*HASH_W-1:0] prod_lo_ff, prod_lo_in;
   logic [HASH_W-1:0]   prod_hi_ff, prod_hi_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [HASH_W-1:0]   quot_ff, quot_in;
   logic [IDX_W:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    probe_ff, probe_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   rd_data_ff;
   vkhs_pkg::rsp_type   res_ff, res_in;
   vkhs_pkg::rsp_type   rsp_ff, rsp_in;

   logic [HASH_W-1:0]   mul_a;
   logic [2*HASH_W-1:0] mul_p;
   logic [HASH_W-1:0]   mix_hi;
   logic [KEY_W-1:0]    mix;
   logic [HASH_W-1:0]   hash_now;
   logic [2*HASH_W-1:0] quot_p;
   logic [IDX_W:0]      quot_s;
   logic [IDX_W:0]      rem_t;
   logic [IDX_W-1:0]    rem_next;
   logic [IDX_W-1:0]    pos_wrap;
   logic                slot_used;
   logic [KEY_W-1:0]    slot_dev;
   logic [KEY_W-1:0]    slot_ino;
   logic                key_match;
   logic                is_insert;
   logic                probe_last;
   logic                store;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_data;
   vkhs_pkg::rsp_type   res_now;

   assign mul_a = cmd.mul_hi ? item_ff.device_id[KEY_W-1:HASH_W] : item_ff.device_id[HASH_W-1:0];
   assign mul_p = mul_a * vkhs_pkg::HASH_MULT;

   assign mix_hi   = prod_lo_ff[2*HASH_W-1:HASH_W] + prod_hi_ff;
   assign mix      = {mix_hi, prod_lo_ff[HASH_W-1:0]} ^ item_ff.inode_number;
   assign hash_now = mix[HASH_W-1:0] ^ mix[KEY_W-1:HASH_W];

   // quotient estimate is exact or one low, so the raw remainder is below twice the size
   assign quot_p   = hash_ff * RECIP;
   assign quot_s   = quot_ff[IDX_W:0] * SLOTS_EXT;
   assign rem_t    = hash_ff[IDX_W:0] - quot_s;
   assign rem_next = (rem_ff >= SLOTS_EXT) ? IDX_W'(rem_ff - SLOTS_EXT) : rem_ff[IDX_W-1:0];

   assign pos_wrap = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;

   assign slot_used  = rd_data_ff[SLOT_W-1];
   assign slot_dev   = rd_data_ff[2*KEY_W-1:KEY_W];
   assign slot_ino   = rd_data_ff[KEY_W-1:0];
   assign key_match  = (slot_dev == item_ff.device_id) && (slot_ino == item_ff.inode_number);
   assign is_insert  = (item_ff.func == vkhs_pkg::FUNC_INSERT);
   assign probe_last = (probe_ff == POS_LAST);

   assign res_now.found_before = slot_used && key_match;
   assign res_now.inserted     = !slot_used && is_insert;
   assign res_now.table_full   = slot_used && !key_match && probe_last && is_insert;

   assign store   = cmd.check && !slot_used && is_insert;
   assign wr_en   = cmd.clear_wr || store;
   assign wr_data = cmd.clear_wr ? '0 : {1'b1, item_ff.device_id, item_ff.inode_number};

   always_comb begin
      item_in    = cmd.load_item ? req_data : item_ff;
      prod_lo_in = cmd.mul_lo ? mul_p : prod_lo_ff;
      prod_hi_in = cmd.mul_hi ? mul_p[HASH_W-1:0] : prod_hi_ff;
      hash_in    = cmd.fold ? hash_now : hash_ff;
      quot_in    = cmd.mod_step ? quot_p[2*HASH_W-1:HASH_W] : quot_ff;
      rem_in     = cmd.mod_step ? rem_t : rem_ff;
      pos_in     = pos_ff;
      probe_in   = probe_ff;
      if (cmd.pos_from_hash) begin
         pos_in   = hash_now[IDX_W-1:0];
         probe_in = '0;
      end else if (cmd.pos_from_rem) begin
         pos_in   = rem_next;
         probe_in = '0;
      end else if (cmd.clear_wr || cmd.advance) begin
         pos_in   = pos_wrap;
         probe_in = probe_ff + 1'b1;
      end
      count_in = store ? count_ff + 1'b1 : count_ff;
      res_in   = cmd.hold_res ? res_now : res_ff;
      rsp_in   = rsp_ff;
      if (cmd.rsp_from_check) begin
         rsp_in = res_now;
      end else if (cmd.rsp_from_hold) begin
         rsp_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      hash_ff    <= hash_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      probe_ff   <= probe_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[pos_ff] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= slot_mem[pos_ff];
      end
   end

   assign status.used       = slot_used;
   assign status.key_match  = key_match;
   assign status.probe_last = probe_last;
   assign status.pos_last   = (pos_ff == POS_LAST);

   assign rsp_data     = rsp_ff;
   assign stored_count = count_ff;

endmodule

FILE: src/vkhs_controller.sv
// Controller of the visited key set: clear pass, hash and index sequencing, probe loop, handshakes.
// Depends on vkhs_pkg; drives vkhs_datapath through cmd_type and reads status_type.
module vkhs_controller #(
   parameter int TABLE_SLOTS = vkhs_pkg::TABLE_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  vkhs_pkg::status_type status,
   output vkhs_pkg::cmd_type    cmd
);

   localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   localparam int MOD_CNT_W = $clog2(vkhs_pkg::MOD_STEPS);
   localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(vkhs_pkg::MOD_STEPS - 1);

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_MUL_LO = 9'b000000100,
      S_MUL_HI = 9'b000001000,
      S_FOLD   = 9'b000010000,
      S_MOD    = 9'b000100000,
      S_READ   = 9'b001000000,
      S_CHECK  = 9'b010000000,
      S_HOLD   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;
   logic                  probe_done;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign probe_done = !status.used || status.key_match || status.probe_last;

   always_comb begin
      state_in     = state_ff;
      mod_cnt_in   = mod_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.pos_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (SLOTS_POW2) begin
               cmd.pos_from_hash = 1'b1;
               state_in          = S_READ;
            end else begin
               mod_cnt_in = '0;
               state_in   = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            mod_cnt_in   = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_LAST) begin
               cmd.pos_from_rem = 1'b1;
               state_in         = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (!probe_done) begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end else if (out_free) begin
               cmd.rsp_from_check = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else begin
               cmd.hold_res = 1'b1;
               state_in     = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               cmd.rsp_from_hold = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mod_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_cnt_ff   <= mod_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/visited_key_hash_set.sv
// Each item is hashed in the MUL_LO, MUL_HI and FOLD states, then reduced to a slot
// index in MOD steps when TABLE_SLOTS is not a power of two. Each probe is a read
// and a compare on the single-port slot memory, over 1 to TABLE_SLOTS slots. A new item
// is taken only in IDLE; the result register frees the input side while rsp waits.
// Reset: synchronous; a clear pass over all slots holds req_stall high after reset.
`include "assert_macros.svh"

module visited_key_hash_set #(
   parameter int TABLE_SLOTS = vkhs_pkg::TABLE_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vkhs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vkhs_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

   vkhs_pkg::cmd_type    cmd;
   vkhs_pkg::status_type status;
   logic [CNT_W-1:0]     stored_count;

   vkhs_controller #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vkhs_datapath #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .status       (status),
      .rsp_data     (rsp_data),
      .stored_count (stored_count)
   );

   `VKHS_ASSERT(a_count_bound, clock, reset, stored_count <= SLOTS_CNT, "stored count exceeds table size")
   `VKHS_ASSERT(a_count_step, clock, reset, (!$past(reset) && !$stable(stored_count)) |-> (stored_count == $past(stored_count) + 1'b1), "stored count moved by other than one")
   `VKHS_ASSERT(a_rsp_flags, clock, reset, rsp_valid |-> $onehot0({rsp_data.found_before, rsp_data.inserted, rsp_data.table_full}), "more than one result flag set")
   `VKHS_NEVER(a_store_no_insert, clock, reset, cmd.check && !status.used && !status.probe_last && cmd.advance, "probe advanced past a free slot")

endmodule

FILE: dv/tb_visited_key_hash_set.sv
`timescale 1ns / 100ps
// Testbench for visited_key_hash_set: sends insert and query items over valid/stall and
// checks each result against a local linear-probing set of (device, inode) keys.
// Depends on vkhs_pkg and the visited_key_hash_set RTL only.
module tb_visited_key_hash_set;

   localparam int SLOTS = vkhs_pkg::TABLE_SLOTS_DEF;
   localparam logic [63:0] GOLDEN_MULT = 64'd2654435761;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 64;
   localparam int RUN_LIMIT_NS = 200_000_000;
   localparam int REPORT_LIMIT = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   vkhs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   vkhs_pkg::rsp_type rsp_data;

   bit                slot_taken [SLOTS];
   logic [63:0]       slot_dev [SLOTS];
   logic [63:0]       slot_ino [SLOTS];
   int                keys_stored = 0;
   vkhs_pkg::req_type known_keys [$];
   vkhs_pkg::rsp_type pending_outcomes [$];
   int                results_seen = 0;
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   logic              rsp_hold = 1'b0;

   visited_key_hash_set dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int home_slot(logic [63:0] dev, logic [63:0] ino);
      logic [63:0] mixed;
      logic [31:0] folded;
      mixed = (dev * GOLDEN_MULT) ^ ino;
      folded = mixed[31:0] ^ mixed[63:32];
      return int'(folded % 32'(SLOTS));
   endfunction

   function automatic vkhs_pkg::req_type make_key(logic f, logic [63:0] dev, logic [63:0] ino);
      vkhs_pkg::req_type key;
      key.func = f;
      key.device_id = dev;
      key.inode_number = ino;
      return key;
   endfunction

   function automatic vkhs_pkg::req_type fresh_key(logic f);
      return make_key(f, rand64(), rand64());
   endfunction

   // steer the inode low bits so the key lands on the given home slot
   function automatic vkhs_pkg::req_type aimed_key(logic f, int slot);
      vkhs_pkg::req_type key;
      int                home;
      key = fresh_key(f);
      home = home_slot(key.device_id, key.inode_number);
      key.inode_number[31:0] = key.inode_number[31:0] ^ (home ^ slot);
      return key;
   endfunction

   // flip one high bit: same home slot, different key
   function automatic vkhs_pkg::req_type near_miss(vkhs_pkg::req_type key);
      int pick;
      pick = $urandom_range(63, 42);
      if ($urandom_range(1)) key.device_id[pick] = ~key.device_id[pick];
      else key.inode_number[pick] = ~key.inode_number[pick];
      return key;
   endfunction

   function automatic vkhs_pkg::req_type known_key(logic f);
      vkhs_pkg::req_type key;
      key = known_keys[$urandom_range(known_keys.size() - 1)];
      key.func = f;
      return key;
   endfunction

   function automatic vkhs_pkg::rsp_type predict_visit(vkhs_pkg::req_type item);
      vkhs_pkg::rsp_type outcome;
      int                pos;
      outcome = '0;
      pos = home_slot(item.device_id, item.inode_number);
      for (int n = 0; n < SLOTS; n++) begin
         if (!slot_taken[pos]) begin
            if (item.func == vkhs_pkg::FUNC_INSERT) begin
               slot_taken[pos] = 1'b1;
               slot_dev[pos] = item.device_id;
               slot_ino[pos] = item.inode_number;
               keys_stored++;
               known_keys.push_back(item);
               outcome.inserted = 1'b1;
            end
            return outcome;
         end
         if (slot_dev[pos] == item.device_id && slot_ino[pos] == item.inode_number) begin
            outcome.found_before = 1'b1;
            return outcome;
         end
         pos = (pos + 1) % SLOTS;
      end
      outcome.table_full = (item.func == vkhs_pkg::FUNC_INSERT);
      return outcome;
   endfunction

   function automatic vkhs_pkg::req_type pick_visit();
      int roll;
      int aim;
      roll = $urandom_range(99);
      aim = int'((SLOTS - 2 + $urandom_range(2) * 341) % SLOTS);
      if (known_keys.size() == 0 || roll < 30) return fresh_key(vkhs_pkg::FUNC_INSERT);
      if (roll < 40) return aimed_key(vkhs_pkg::FUNC_INSERT, aim);
      if (roll < 55) return known_key(vkhs_pkg::FUNC_INSERT);
      if (roll < 75) return known_key(vkhs_pkg::FUNC_QUERY);
      if (roll < 85) return near_miss(known_key(logic'($urandom_range(1))));
      if (roll < 93) return fresh_key(vkhs_pkg::FUNC_QUERY);
      return aimed_key(vkhs_pkg::FUNC_QUERY, aim);
   endfunction

   task automatic send_item(input vkhs_pkg::req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(predict_visit(item));
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH result %0d: %s", results_seen, msg);
   endtask

   always @(posedge clock) begin : check_results
      vkhs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch($sformatf("no item pending, got found=%0b inserted=%0b full=%0b",
                                    rsp_data.found_before, rsp_data.inserted,
                                    rsp_data.table_full));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.found_before !== want.found_before ||
                rsp_data.inserted !== want.inserted ||
                rsp_data.table_full !== want.table_full) begin
               flag_mismatch($sformatf(
                  "expected found=%0b inserted=%0b full=%0b, got found=%0b inserted=%0b full=%0b",
                  want.found_before, want.inserted, want.table_full,
                  rsp_data.found_before, rsp_data.inserted, rsp_data.table_full));
            end
         end
         results_seen++;
      end
      rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
   end

   task automatic test_directed();
      vkhs_pkg::req_type chain [3];
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_item(make_key(vkhs_pkg::FUNC_QUERY, '0, '0));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, '0, '0));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, '0, '0));
      send_item(make_key(vkhs_pkg::FUNC_QUERY, '0, '0));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, '0, '1));
      send_item(make_key(vkhs_pkg::FUNC_QUERY, '0, '1));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, '1, '1));
      send_item(make_key(vkhs_pkg::FUNC_QUERY, '1, '1));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, '1, '0));
      send_item(make_key(vkhs_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000,
                         64'h8000_0000_0000_0000));
      send_item(make_key(vkhs_pkg::FUNC_QUERY, 64'h8000_0000_0000_0000, '0));
      // chain on the last slot, wrapping into the occupied low slots
      foreach (chain[i]) begin
         chain[i] = aimed_key(vkhs_pkg::FUNC_INSERT, SLOTS - 1);
         send_item(chain[i]);
      end
      chain[2].func = vkhs_pkg::FUNC_QUERY;
      send_item(chain[2]);
      chain[2].func = vkhs_pkg::FUNC_INSERT;
      send_item(chain[2]);
      send_item(aimed_key(vkhs_pkg::FUNC_QUERY, SLOTS - 1));
      send_item(near_miss(chain[0]));
      chain[1].func = vkhs_pkg::FUNC_QUERY;
      send_item(near_miss(chain[1]));
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_item(pick_visit());
   endtask

   task automatic test_random_traffic();
      run_phase(200, 0, 0);
      run_phase(200, 69, 0);
      run_phase(200, 0, 69);
      run_phase(200, 25, 25);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         repeat (12) send_item(pick_visit());
      join
   endtask

   task automatic test_fill_to_capacity();
      send_idle_pct = 25;
      recv_stall_pct = 25;
      while (keys_stored < SLOTS) begin
         if ($urandom_range(9) == 0) send_item(known_key(logic'($urandom_range(1))));
         else send_item(fresh_key(vkhs_pkg::FUNC_INSERT));
      end
   endtask

   task automatic test_full_table();
      send_idle_pct = 0;
      recv_stall_pct = 25;
      repeat (10) send_item(fresh_key(vkhs_pkg::FUNC_INSERT));
      repeat (6) send_item(fresh_key(vkhs_pkg::FUNC_QUERY));
      repeat (20) send_item(known_key(logic'($urandom_range(1))));
      repeat (6) send_item(near_miss(known_key(logic'($urandom_range(1)))));
      send_item(aimed_key(vkhs_pkg::FUNC_INSERT, SLOTS - 1));
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_backpressure();
      test_fill_to_capacity();
      test_full_table();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/vkhs_pkg.sv
src/vkhs_datapath.sv
src/vkhs_controller.sv
src/visited_key_hash_set.sv
dv/tb_visited_key_hash_set.sv
